@@ src/suffix_array_lcp_builder_macros.svh @@
// Assertion macros used by the port checker
`ifndef SUFFIX_ARRAY_LCP_BUILDER_MACROS_SVH
`define SUFFIX_ARRAY_LCP_BUILDER_MACROS_SVH

// same-cycle implication, muted in reset
`define SALCP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, muted in reset
`define SALCP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, live in reset
`define SALCP_ASSERT_NXT_NR(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/salcp_pkg.sv @@
// Types and constants shared by the suffix array and LCP builder
package salcp_pkg;

  localparam int BYTE_VALUES = 256;

  typedef logic [11:0] start_t;
  typedef logic [11:0] lcp_t;
  typedef logic [12:0] len_t;
  typedef logic [11:0] rank_t;
  typedef logic [7:0]  byte_t;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_READ   = 1'b1
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_NOT_BUILT = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef struct packed {
    cmd_code_t cmd;
    byte_t     char_byte;
    logic      last;
    rank_t     rank_index;
  } req_item_t;

  typedef struct packed {
    start_t  suffix_start;
    lcp_t    lcp_len;
    len_t    length_now;
    status_t status;
  } rsp_item_t;

  typedef enum logic [5:0] {
    S_IDLE, S_APPEND, S_RD_ADDR, S_RESP,
    S_IN0, S_IN1,
    S_CLR, S_CNT0, S_CNT1, S_CNT2, S_PRE0, S_PRE1,
    S_SCT0, S_SCT1, S_SCT2, S_SCT3,
    S_DBL, S_G0, S_G1, S_G2,
    S_RNK0, S_RNK1, S_RNK2, S_RNK3, S_RNKEND,
    S_INV0, S_INV1,
    S_KS0, S_KS1, S_KS2, S_KS3, S_KS4, S_KS5
  } state_t;

  typedef struct packed {
    state_t op;
    logic   take;
    logic   load_rsp;
  } dp_cmd_t;

  typedef struct packed {
    logic req_read;
    logic start_build;
    logic i_end;
    logic i_zero;
    logic nb_last;
    logic first_sort;
    logic shift_gt;
    logic nb_ge;
    logic r_zero;
    logic ks_cont;
    logic text_eq;
  } dp_stat_t;

endpackage

@@ src/salcp_if.sv @@
// Request and response channel interfaces
interface salcp_req_if;
  logic                 valid;
  logic                 ready;
  salcp_pkg::req_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface salcp_rsp_if;
  logic                 valid;
  logic                 ready;
  salcp_pkg::rsp_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/salcp_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module salcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/salcp_ctrl.sv @@
// Sequencer for item handling, doubling sort passes and the LCP pass
module salcp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  salcp_pkg::dp_stat_t stat,
  output salcp_pkg::dp_cmd_t  cmd
);

  salcp_pkg::state_t state, state_next;
  logic              load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= salcp_pkg::S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= load | (rsp_valid & ~rsp_ready);
    end
  end

  always_comb begin
    state_next   = state;
    req_ready    = 1'b0;
    load         = 1'b0;
    cmd.op       = state;
    cmd.take     = 1'b0;
    cmd.load_rsp = 1'b0;
    unique case (state)
      salcp_pkg::S_IDLE: begin
        req_ready = 1'b1;
        cmd.take  = req_valid;
        if (req_valid) begin
          state_next = stat.req_read ? salcp_pkg::S_RD_ADDR : salcp_pkg::S_APPEND;
        end
      end
      salcp_pkg::S_APPEND:  state_next = salcp_pkg::S_RESP;
      salcp_pkg::S_RD_ADDR: state_next = salcp_pkg::S_RESP;
      salcp_pkg::S_RESP: begin
        load         = ~rsp_valid | rsp_ready;
        cmd.load_rsp = load;
        if (load) begin
          state_next = stat.start_build ? salcp_pkg::S_IN0 : salcp_pkg::S_IDLE;
        end
      end
      salcp_pkg::S_IN0:  state_next = stat.i_end ? salcp_pkg::S_CLR : salcp_pkg::S_IN1;
      salcp_pkg::S_IN1:  state_next = salcp_pkg::S_IN0;
      salcp_pkg::S_CLR:  state_next = stat.nb_last ? salcp_pkg::S_CNT0 : salcp_pkg::S_CLR;
      salcp_pkg::S_CNT0: state_next = stat.i_end ? salcp_pkg::S_PRE0 : salcp_pkg::S_CNT1;
      salcp_pkg::S_CNT1: state_next = salcp_pkg::S_CNT2;
      salcp_pkg::S_CNT2: state_next = salcp_pkg::S_CNT0;
      salcp_pkg::S_PRE0: state_next = salcp_pkg::S_PRE1;
      salcp_pkg::S_PRE1: state_next = stat.nb_last ? salcp_pkg::S_SCT0 : salcp_pkg::S_PRE0;
      salcp_pkg::S_SCT0: begin
        if (!stat.i_zero) begin
          state_next = salcp_pkg::S_SCT1;
        end else begin
          state_next = stat.first_sort ? salcp_pkg::S_DBL : salcp_pkg::S_RNK0;
        end
      end
      salcp_pkg::S_SCT1: state_next = salcp_pkg::S_SCT2;
      salcp_pkg::S_SCT2: state_next = salcp_pkg::S_SCT3;
      salcp_pkg::S_SCT3: state_next = salcp_pkg::S_SCT0;
      salcp_pkg::S_DBL:  state_next = stat.shift_gt ? salcp_pkg::S_INV0 : salcp_pkg::S_G0;
      salcp_pkg::S_G0:   state_next = stat.i_end ? salcp_pkg::S_G1 : salcp_pkg::S_G0;
      salcp_pkg::S_G1:   state_next = stat.i_end ? salcp_pkg::S_CLR : salcp_pkg::S_G2;
      salcp_pkg::S_G2:   state_next = salcp_pkg::S_G1;
      salcp_pkg::S_RNK0: state_next = stat.i_end ? salcp_pkg::S_RNKEND : salcp_pkg::S_RNK1;
      salcp_pkg::S_RNK1: state_next = salcp_pkg::S_RNK2;
      salcp_pkg::S_RNK2: state_next = salcp_pkg::S_RNK3;
      salcp_pkg::S_RNK3: state_next = salcp_pkg::S_RNK0;
      salcp_pkg::S_RNKEND: state_next = stat.nb_ge ? salcp_pkg::S_INV0 : salcp_pkg::S_DBL;
      salcp_pkg::S_INV0: state_next = stat.i_end ? salcp_pkg::S_KS0 : salcp_pkg::S_INV1;
      salcp_pkg::S_INV1: state_next = salcp_pkg::S_INV0;
      salcp_pkg::S_KS0:  state_next = stat.i_end ? salcp_pkg::S_IDLE : salcp_pkg::S_KS1;
      salcp_pkg::S_KS1:  state_next = stat.r_zero ? salcp_pkg::S_KS0 : salcp_pkg::S_KS2;
      salcp_pkg::S_KS2:  state_next = salcp_pkg::S_KS3;
      salcp_pkg::S_KS3:  state_next = stat.ks_cont ? salcp_pkg::S_KS4 : salcp_pkg::S_KS0;
      salcp_pkg::S_KS4:  state_next = salcp_pkg::S_KS5;
      salcp_pkg::S_KS5:  state_next = stat.text_eq ? salcp_pkg::S_KS3 : salcp_pkg::S_KS0;
      default:           state_next = salcp_pkg::S_IDLE;
    endcase
  end

endmodule

@@ src/salcp_dp.sv @@
// Datapath: stores, counters and compare logic for the build and the reads
module salcp_dp #(
  parameter int MAX_LEN = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  salcp_pkg::dp_cmd_t   cmd,
  output salcp_pkg::dp_stat_t  stat,
  input  salcp_pkg::req_item_t req_data,
  output salcp_pkg::rsp_item_t rsp_data
);

  localparam int IW        = $clog2(MAX_LEN);
  localparam int LW        = $clog2(MAX_LEN + 1);
  localparam int SW        = LW + 1;
  localparam int RW        = (IW > 8) ? IW : 8;
  localparam int CNT_DEPTH = MAX_LEN + salcp_pkg::BYTE_VALUES;
  localparam int CAW       = $clog2(CNT_DEPTH);
  localparam int CW        = (LW > 9) ? LW : 9;

  salcp_pkg::req_item_t item;
  logic [LW-1:0] len;
  logic          built;
  logic          ovf;
  logic [CW-1:0] i;
  logic [LW-1:0] c;
  logic [CW-1:0] nb;
  logic [SW-1:0] shift;
  logic [LW-1:0] sum;
  logic [LW-1:0] h;
  logic [IW-1:0] b;
  logic [IW-1:0] e;
  logic [RW-1:0] key;
  logic [IW-1:0] r;
  logic [7:0]    ta;
  logic [RW-1:0] yb;
  logic [RW-1:0] prev_y;
  logic [RW-1:0] prev_ys;
  logic          prev_in;
  logic          first_sort;
  logic          sel;

  // memory ports
  logic          text_we;
  logic [IW-1:0] text_waddr, text_raddr;
  logic [7:0]    text_q;
  logic          sa_we;
  logic [IW-1:0] sa_waddr, sa_raddr, sa_q;
  logic          lcp_we;
  logic [IW-1:0] lcp_waddr, lcp_wdata, lcp_raddr, lcp_q;
  logic          cnt_we;
  logic [CAW-1:0] cnt_waddr, cnt_raddr;
  logic [LW-1:0] cnt_wdata, cnt_q;
  logic          x_we, y_we;
  logic [IW-1:0] x_waddr, x_raddr, y_waddr, y_raddr;
  logic [RW-1:0] x_wdata, y_wdata, x_q, y_q;
  logic          rk0_we, rk1_we;
  logic [IW-1:0] rk0_waddr, rk0_raddr, rk1_waddr, rk1_raddr;
  logic [RW-1:0] rk0_wdata, rk1_wdata, rk0_q, rk1_q;

  logic [LW-1:0] len_eff;
  logic          full_eff;
  logic [SW-1:0] b_sh;
  logic          bin;
  logic          diff;
  logic          sa_ge_shift;

  salcp_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text (
    .clk(clk), .we(text_we), .waddr(text_waddr), .wdata(item.char_byte),
    .raddr(text_raddr), .rdata(text_q)
  );
  salcp_ram #(.WIDTH(IW), .DEPTH(MAX_LEN)) u_sa (
    .clk(clk), .we(sa_we), .waddr(sa_waddr), .wdata(e),
    .raddr(sa_raddr), .rdata(sa_q)
  );
  salcp_ram #(.WIDTH(IW), .DEPTH(MAX_LEN)) u_lcp (
    .clk(clk), .we(lcp_we), .waddr(lcp_waddr), .wdata(lcp_wdata),
    .raddr(lcp_raddr), .rdata(lcp_q)
  );
  salcp_ram #(.WIDTH(LW), .DEPTH(CNT_DEPTH)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_q)
  );
  salcp_ram #(.WIDTH(RW), .DEPTH(MAX_LEN)) u_rk0 (
    .clk(clk), .we(rk0_we), .waddr(rk0_waddr), .wdata(rk0_wdata),
    .raddr(rk0_raddr), .rdata(rk0_q)
  );
  salcp_ram #(.WIDTH(RW), .DEPTH(MAX_LEN)) u_rk1 (
    .clk(clk), .we(rk1_we), .waddr(rk1_waddr), .wdata(rk1_wdata),
    .raddr(rk1_raddr), .rdata(rk1_q)
  );

  // the two rank stores swap roles after every doubling sort
  assign x_q       = sel ? rk1_q : rk0_q;
  assign y_q       = sel ? rk0_q : rk1_q;
  assign rk0_we    = sel ? y_we : x_we;
  assign rk0_waddr = sel ? y_waddr : x_waddr;
  assign rk0_wdata = sel ? y_wdata : x_wdata;
  assign rk0_raddr = sel ? y_raddr : x_raddr;
  assign rk1_we    = sel ? x_we : y_we;
  assign rk1_waddr = sel ? x_waddr : y_waddr;
  assign rk1_wdata = sel ? x_wdata : y_wdata;
  assign rk1_raddr = sel ? x_raddr : y_raddr;

  assign len_eff     = built ? '0 : len;
  assign full_eff    = (len_eff == LW'(MAX_LEN));
  assign b_sh        = SW'(b) + shift;
  assign bin         = (b_sh < SW'(len));
  assign diff        = (i == '0) || (prev_y != yb) || (prev_in != bin) ||
                       (prev_in && (prev_ys != y_q));
  assign sa_ge_shift = (SW'(sa_q) >= shift);

  assign stat.req_read    = (req_data.cmd == salcp_pkg::CMD_READ);
  assign stat.start_build = (item.cmd == salcp_pkg::CMD_APPEND) && item.last && (len != '0);
  assign stat.i_end       = (i == CW'(len));
  assign stat.i_zero      = (i == '0);
  assign stat.nb_last     = (i == nb - CW'(1));
  assign stat.first_sort  = first_sort;
  assign stat.shift_gt    = (shift > SW'(len));
  assign stat.nb_ge       = (nb >= CW'(len));
  assign stat.r_zero      = (y_q == '0);
  assign stat.ks_cont     = ((SW'(i) + SW'(h)) < SW'(len)) && ((SW'(b) + SW'(h)) < SW'(len));
  assign stat.text_eq     = (text_q == ta);

  always_comb begin
    text_we    = 1'b0;
    text_waddr = IW'(len_eff);
    text_raddr = '0;
    sa_we      = 1'b0;
    sa_waddr   = IW'(cnt_q - LW'(1));
    sa_raddr   = IW'(item.rank_index);
    lcp_we     = 1'b0;
    lcp_waddr  = r;
    lcp_wdata  = IW'(h);
    lcp_raddr  = IW'(item.rank_index);
    cnt_we     = 1'b0;
    cnt_waddr  = CAW'(key);
    cnt_wdata  = '0;
    cnt_raddr  = CAW'(x_q);
    x_we       = 1'b0;
    x_waddr    = IW'(i);
    x_wdata    = RW'(text_q);
    x_raddr    = IW'(i);
    y_we       = 1'b0;
    y_waddr    = IW'(i);
    y_wdata    = RW'(i);
    y_raddr    = IW'(i);
    unique case (cmd.op)
      salcp_pkg::S_APPEND: text_we = ~full_eff;
      salcp_pkg::S_IN0:    text_raddr = IW'(i);
      salcp_pkg::S_IN1: begin
        x_we = 1'b1;
        y_we = 1'b1;
      end
      salcp_pkg::S_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = CAW'(i);
      end
      salcp_pkg::S_CNT2: begin
        cnt_we    = 1'b1;
        cnt_wdata = cnt_q + LW'(1);
      end
      salcp_pkg::S_PRE0: cnt_raddr = CAW'(i);
      salcp_pkg::S_PRE1: begin
        cnt_we    = 1'b1;
        cnt_waddr = CAW'(i);
        cnt_wdata = cnt_q + sum;
      end
      salcp_pkg::S_SCT0: y_raddr = IW'(i - CW'(1));
      salcp_pkg::S_SCT1: x_raddr = IW'(y_q);
      salcp_pkg::S_SCT3: begin
        cnt_we    = 1'b1;
        cnt_wdata = cnt_q - LW'(1);
        sa_we     = 1'b1;
      end
      salcp_pkg::S_G0: begin
        y_we    = 1'b1;
        y_waddr = IW'(c);
      end
      salcp_pkg::S_G1:   sa_raddr = IW'(i);
      salcp_pkg::S_G2: begin
        y_we    = sa_ge_shift;
        y_waddr = IW'(c);
        y_wdata = RW'(SW'(sa_q) - shift);
      end
      salcp_pkg::S_RNK0: sa_raddr = IW'(i);
      salcp_pkg::S_RNK1: y_raddr = sa_q;
      salcp_pkg::S_RNK2: y_raddr = IW'(b_sh);
      salcp_pkg::S_RNK3: begin
        x_we    = 1'b1;
        x_waddr = b;
        x_wdata = diff ? RW'(nb) : RW'(nb - CW'(1));
      end
      salcp_pkg::S_INV0: sa_raddr = IW'(i);
      salcp_pkg::S_INV1: begin
        y_we    = 1'b1;
        y_waddr = sa_q;
      end
      salcp_pkg::S_KS0:  y_raddr = IW'(i);
      salcp_pkg::S_KS1: begin
        sa_raddr  = IW'(y_q) - IW'(1);
        lcp_we    = (y_q == '0);
        lcp_waddr = '0;
        lcp_wdata = '0;
      end
      salcp_pkg::S_KS3: begin
        text_raddr = IW'(SW'(i) + SW'(h));
        lcp_we     = ~stat.ks_cont;
      end
      salcp_pkg::S_KS4:  text_raddr = IW'(SW'(b) + SW'(h));
      salcp_pkg::S_KS5:  lcp_we = ~stat.text_eq;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len   <= '0;
      built <= 1'b0;
    end else begin
      unique case (cmd.op)
        salcp_pkg::S_IDLE: begin
          if (cmd.take) begin
            item <= req_data;
          end
        end
        salcp_pkg::S_APPEND: begin
          built <= 1'b0;
          ovf   <= full_eff;
          len   <= full_eff ? len_eff : len_eff + LW'(1);
        end
        salcp_pkg::S_RESP: begin
          if (cmd.load_rsp) begin
            rsp_data.length_now   <= salcp_pkg::len_t'(len);
            rsp_data.suffix_start <= '0;
            rsp_data.lcp_len      <= '0;
            if (item.cmd == salcp_pkg::CMD_APPEND) begin
              rsp_data.status <= ovf ? salcp_pkg::ST_OVERFLOW : salcp_pkg::ST_OK;
            end else if (!built) begin
              rsp_data.status <= salcp_pkg::ST_NOT_BUILT;
            end else if (item.rank_index >= len) begin
              rsp_data.status <= salcp_pkg::ST_RANGE;
            end else begin
              rsp_data.status       <= salcp_pkg::ST_OK;
              rsp_data.suffix_start <= salcp_pkg::start_t'(sa_q);
              rsp_data.lcp_len      <= salcp_pkg::lcp_t'(lcp_q);
            end
          end
          i          <= '0;
          nb         <= CW'(salcp_pkg::BYTE_VALUES);
          first_sort <= 1'b1;
          sel        <= 1'b0;
        end
        salcp_pkg::S_IN0: begin
          if (stat.i_end) begin
            i <= '0;
          end
        end
        salcp_pkg::S_IN1:  i <= i + CW'(1);
        salcp_pkg::S_CLR:  i <= stat.nb_last ? '0 : i + CW'(1);
        salcp_pkg::S_CNT0: begin
          if (stat.i_end) begin
            i   <= '0;
            sum <= '0;
          end
        end
        salcp_pkg::S_CNT1: key <= x_q;
        salcp_pkg::S_CNT2: i <= i + CW'(1);
        salcp_pkg::S_PRE1: begin
          sum <= cnt_q + sum;
          i   <= stat.nb_last ? CW'(len) : i + CW'(1);
        end
        salcp_pkg::S_SCT0: begin
          if (stat.i_zero) begin
            if (first_sort) begin
              first_sort <= 1'b0;
              shift      <= SW'(1);
            end else begin
              sel <= ~sel;
              i   <= '0;
              nb  <= '0;
            end
          end
        end
        salcp_pkg::S_SCT1: e <= IW'(y_q);
        salcp_pkg::S_SCT2: key <= x_q;
        salcp_pkg::S_SCT3: i <= i - CW'(1);
        salcp_pkg::S_DBL: begin
          c <= '0;
          i <= stat.shift_gt ? '0 : CW'(SW'(len) - shift);
        end
        salcp_pkg::S_G0: begin
          if (stat.i_end) begin
            i <= '0;
          end else begin
            c <= c + LW'(1);
            i <= i + CW'(1);
          end
        end
        salcp_pkg::S_G1: begin
          if (stat.i_end) begin
            i <= '0;
          end
        end
        salcp_pkg::S_G2: begin
          if (sa_ge_shift) begin
            c <= c + LW'(1);
          end
          i <= i + CW'(1);
        end
        salcp_pkg::S_RNK1: b <= sa_q;
        salcp_pkg::S_RNK2: yb <= y_q;
        salcp_pkg::S_RNK3: begin
          prev_y  <= yb;
          prev_ys <= y_q;
          prev_in <= bin;
          if (diff) begin
            nb <= nb + CW'(1);
          end
          i <= i + CW'(1);
        end
        salcp_pkg::S_RNKEND: begin
          if (stat.nb_ge) begin
            i <= '0;
          end else begin
            shift <= shift << 1;
          end
        end
        salcp_pkg::S_INV0: begin
          if (stat.i_end) begin
            i <= '0;
            h <= '0;
          end
        end
        salcp_pkg::S_INV1: i <= i + CW'(1);
        salcp_pkg::S_KS0: begin
          if (stat.i_end) begin
            built <= 1'b1;
          end
        end
        salcp_pkg::S_KS1: begin
          r <= IW'(y_q);
          if (stat.r_zero) begin
            h <= '0;
            i <= i + CW'(1);
          end else if (h != '0) begin
            h <= h - LW'(1);
          end
        end
        salcp_pkg::S_KS2: b <= sa_q;
        salcp_pkg::S_KS3: begin
          if (!stat.ks_cont) begin
            i <= i + CW'(1);
          end
        end
        salcp_pkg::S_KS4: ta <= text_q;
        salcp_pkg::S_KS5: begin
          if (stat.text_eq) begin
            h <= h + LW'(1);
          end else begin
            i <= i + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ src/suffix_array_lcp_builder.sv @@
// Top level of the suffix array and LCP builder
//
// Usage: req carries one item per transfer. An append (cmd 0) stores char_byte at the
// end of the string, or starts a new string once built; last set on an append starts
// the build. A read (cmd 1) returns the suffix start and LCP at rank_index. Every
// request gives exactly one transfer on rsp. After its transfer an append or a read
// passes S_APPEND or S_RD_ADDR, then S_RESP loads its result into the output register.
// Requests are taken one at a time, each after the previous result is loaded; a new
// one is taken while the previous result still waits on rsp. The build uses the single
// read port of each store to load the n bytes, run a counting sort over the nb buckets
// of each pass with a regrouping step before each doubling sort, build the inverse
// order and run the LCP pass. No request is taken during the build.
// Reset clears the length, the built flag and the output valid; store contents are not
// cleared and no clearing pass runs. A stalled rsp holds its result and stops further
// requests after the next one has been taken.
module suffix_array_lcp_builder #(
  parameter int MAX_LEN = 4096
) (
  input logic         clk,
  input logic         rst,
  salcp_req_if.sink   req,
  salcp_rsp_if.source rsp
);

  salcp_pkg::dp_cmd_t  cmd;
  salcp_pkg::dp_stat_t stat;

  salcp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  salcp_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .req_data (req.data),
    .rsp_data (rsp.data)
  );

endmodule

@@ src/salcp_chk.sv @@
// Port checker for the suffix array and LCP builder, bound to the top level
`include "suffix_array_lcp_builder_macros.svh"

module salcp_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input salcp_pkg::req_item_t req_data,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input salcp_pkg::rsp_item_t rsp_data
);

  logic req_xfer;
  logic rsp_err;
  logic rsp_zero;
  assign req_xfer = req_valid && req_ready;
  assign rsp_err  = rsp_valid && (rsp_data.status != salcp_pkg::ST_OK);
  assign rsp_zero = (rsp_data.suffix_start == '0) && (rsp_data.lcp_len == '0);

  `SALCP_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")
  `SALCP_ASSERT_NXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready, $stable(rsp_data), "rsp changed")
  `SALCP_ASSERT_NXT_NR(a_rst_quiet, clk, rst, !rsp_valid, "rsp valid after reset")
  `SALCP_ASSERT_NXT(a_busy_after_xfer, clk, rst, req_xfer, !req_ready, "ready after transfer")
  `SALCP_ASSERT_IMP(a_err_zero, clk, rst, rsp_err, rsp_zero, "error result not zero")

endmodule

bind suffix_array_lcp_builder salcp_chk u_salcp_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_data  (req.data),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
